@@ src/two_frame_deinterlace_pixel_assert.svh @@
// Assertion macros used by the deinterlacer top level.
`ifndef TWO_FRAME_DEINTERLACE_PIXEL_ASSERT_SVH
`define TWO_FRAME_DEINTERLACE_PIXEL_ASSERT_SVH

`ifndef SYNTHESIS
`define TFDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TFDI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TFDI_ASSERT(label, prop, msg)
`define TFDI_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/tfdi_pkg.sv @@
// Types and constants of the two-frame deinterlacer.
`timescale 1ns / 1ps

package tfdi_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned TolW  = 13;
  localparam int unsigned SqW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TolW-1:0] SpatialTolReset  = 13'd600;
  localparam logic [TolW-1:0] TemporalTolReset = 13'd300;
  localparam logic            HalvedModeReset  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpatialTol  = 2'd0,
    CfgTemporalTol = 2'd1,
    CfgHalvedMode  = 2'd2
  } cfg_idx_e;

  // Settings that every difference check uses.
  typedef struct packed {
    logic [TolW-1:0] tol;
    logic            halved;
  } diff_cfg_t;

endpackage

@@ src/tfdi_diff_check.sv @@
// Squared luma difference compared against a tolerance.
`timescale 1ns / 1ps

module tfdi_diff_check
  import tfdi_pkg::*;
(
  input  logic [PixW-1:0] a_i,
  input  logic [PixW-1:0] b_i,
  input  diff_cfg_t       cfg_i,
  output logic            diff_o
);

  logic signed [PixW:0] diff;
  logic signed [PixW:0] half;
  logic        [PixW:0] abs_full;
  logic        [PixW:0] abs_half;
  logic      [PixW-1:0] mag;
  logic       [SqW-1:0] sq;
  logic      [TolW-1:0] limit;

  always_comb begin
    diff     = $signed({1'b0, a_i}) - $signed({1'b0, b_i});
    half     = diff >>> 1;
    abs_full = diff[PixW] ? 9'(-diff) : 9'(diff);
    abs_half = half[PixW] ? 9'(-half) : 9'(half);
    // In halved mode the floored half difference is at most 128 in magnitude.
    mag      = cfg_i.halved ? abs_half[PixW-1:0] : abs_full[PixW-1:0];
    sq       = {{(SqW-PixW){1'b0}}, mag} * {{(SqW-PixW){1'b0}}, mag};
    limit    = cfg_i.halved ? {2'b00, cfg_i.tol[TolW-1:2]} : cfg_i.tol;
    diff_o   = sq > {{(SqW-TolW){1'b0}}, limit};
  end

endmodule

@@ src/two_frame_deinterlace_pixel.sv @@
// Top level of the two-frame motion-adaptive deinterlacer for one pixel slot.
//
// One transfer on the input channel carries the current top, bottom and middle
// pixels plus the previous frame's middle, top and bottom luma. One transfer on
// the output channel returns the chosen luma and chroma and a flag that tells
// whether the middle pixel was woven or the top/bottom average was used.
// An input register holds the item for the difference checks and the selection,
// whose result the result register takes. Throughput is one pixel per cycle while
// the receiver does not stall; the result register frees as it is read, so input
// and output can move together. When the receiver stalls, the result holds and
// the input register still takes one more item if it is empty, after which the
// input channel stalls too. The configuration port is always ready; tolerances
// and the halved mode take effect for each item in the input register after the
// write, also one held there by a stall. Writes to an unlisted index are dropped.
// Reset empties both registers and loads tolerances 600 and 300 with halved mode on.
`timescale 1ns / 1ps

module two_frame_deinterlace_pixel
  import tfdi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PixW-1:0]    top_luma_i,
  input  logic [PixW-1:0]    top_chroma_i,
  input  logic [PixW-1:0]    bottom_luma_i,
  input  logic [PixW-1:0]    bottom_chroma_i,
  input  logic [PixW-1:0]    mid_luma_i,
  input  logic [PixW-1:0]    mid_chroma_i,
  input  logic [PixW-1:0]    prev_mid_luma_i,
  input  logic [PixW-1:0]    prev_top_luma_i,
  input  logic [PixW-1:0]    prev_bottom_luma_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PixW-1:0]    out_luma_o,
  output logic [PixW-1:0]    out_chroma_o,
  output logic               wove_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TolW-1:0]    cfg_data_i
);

`include "two_frame_deinterlace_pixel_assert.svh"

  logic [TolW-1:0] spatial_tol_q;
  logic [TolW-1:0] temporal_tol_q;
  logic            halved_mode_q;

  logic            s1_valid_q;
  logic [PixW-1:0] t_y_q, t_c_q, b_y_q, b_c_q, m_y_q, m_c_q, pm_y_q, pt_y_q, pb_y_q;

  logic            s2_load;
  logic            s1_load;

  diff_cfg_t       spatial_cfg;
  diff_cfg_t       temporal_cfg;
  logic            diff_top, diff_bot, new_mid, new_top, new_bot;
  logic            weave;
  logic [PixW:0]   avg_y, avg_c;
  logic [PixW-1:0] luma_d, chroma_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spatial_tol_q  <= SpatialTolReset;
      temporal_tol_q <= TemporalTolReset;
      halved_mode_q  <= HalvedModeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgSpatialTol:  spatial_tol_q  <= cfg_data_i;
        CfgTemporalTol: temporal_tol_q <= cfg_data_i;
        CfgHalvedMode:  halved_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The result register moves when it is empty or being read; the input
  // register moves when it is empty or its item moves on.
  assign s2_load    = !out_valid_o || !out_stall_i;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      t_y_q  <= top_luma_i;
      t_c_q  <= top_chroma_i;
      b_y_q  <= bottom_luma_i;
      b_c_q  <= bottom_chroma_i;
      m_y_q  <= mid_luma_i;
      m_c_q  <= mid_chroma_i;
      pm_y_q <= prev_mid_luma_i;
      pt_y_q <= prev_top_luma_i;
      pb_y_q <= prev_bottom_luma_i;
    end
  end

  assign spatial_cfg  = '{tol: spatial_tol_q,  halved: halved_mode_q};
  assign temporal_cfg = '{tol: temporal_tol_q, halved: halved_mode_q};

  tfdi_diff_check u_diff_top (.a_i(t_y_q), .b_i(m_y_q),  .cfg_i(spatial_cfg),  .diff_o(diff_top));
  tfdi_diff_check u_diff_bot (.a_i(b_y_q), .b_i(m_y_q),  .cfg_i(spatial_cfg),  .diff_o(diff_bot));
  tfdi_diff_check u_new_mid  (.a_i(m_y_q), .b_i(pm_y_q), .cfg_i(temporal_cfg), .diff_o(new_mid));
  tfdi_diff_check u_new_top  (.a_i(t_y_q), .b_i(pt_y_q), .cfg_i(temporal_cfg), .diff_o(new_top));
  tfdi_diff_check u_new_bot  (.a_i(b_y_q), .b_i(pb_y_q), .cfg_i(temporal_cfg), .diff_o(new_bot));

  always_comb begin
    weave    = !(diff_top && diff_bot) || !(new_mid || new_top || new_bot);
    avg_y    = ({1'b0, t_y_q} + {1'b0, b_y_q} + 9'd1) >> 1;
    avg_c    = ({1'b0, t_c_q} + {1'b0, b_c_q} + 9'd1) >> 1;
    luma_d   = weave ? m_y_q : avg_y[PixW-1:0];
    chroma_d = weave ? m_c_q : avg_c[PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_load) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      out_luma_o   <= luma_d;
      out_chroma_o <= chroma_d;
      wove_o       <= weave;
    end
  end

  `TFDI_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled while empty")
  `TFDI_ASSERT(a_no_stall_free_out, !out_stall_i |-> !in_stall_o, "input stalled with free output")
  `TFDI_ASSERT(a_item_reaches_out, (s1_valid_q && s2_load) |=> out_valid_o, "item lost on its way out")
  `TFDI_ASSERT(a_halved_write, (cfg_valid_i && cfg_index_i == CfgHalvedMode) |=> halved_mode_q == $past(cfg_data_i[0]), "halved mode write lost")
  `TFDI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!s1_valid_q && !out_valid_o), "pipeline not empty in reset")

endmodule
